FILE: rtl/core/tkil_pkg.sv
// Package for the top-k insertion list: word types, opcodes, controller states
// and the command group passed from controller to datapath.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tkil_pkg;

	localparam int SCORE_BITS = 32;
	localparam int ID_BITS = 32;
	localparam int RANK_BITS = 4;
	localparam int LIMIT_BITS = 5;
	localparam int OPCODE_BITS = 2;

	localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_BITS-1:0] OP_READ = 2'd1;
	localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 2'd2;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

	typedef struct packed {
		logic [OPCODE_BITS-1:0] opcode;
		logic [SCORE_BITS-1:0] cand_score;
		logic [ID_BITS-1:0] cand_id;
	} req_t;

	typedef struct packed {
		logic entry_valid;
		logic [SCORE_BITS-1:0] entry_score;
		logic [ID_BITS-1:0] entry_id;
		logic [RANK_BITS-1:0] entry_rank;
		logic last_entry;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} ctl_state_t;

	typedef struct packed {
		logic insert;
		logic clear;
		logic emit;
		logic emit_empty;
		logic last;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/tkil_ctrl.sv
// Controller of the top-k insertion list: decodes the opcode, walks the rank
// counter during a read-out and issues commands to the datapath. Uses tkil_pkg.
`default_nettype none

module tkil_ctrl #(
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [tkil_pkg::OPCODE_BITS-1:0] opcode,
	input  wire logic [CNT_W-1:0] fill,
	output logic busy,
	output tkil_pkg::cmd_t cmd,
	output logic [IDX_W-1:0] rank
);
	import tkil_pkg::*;

	ctl_state_t state_q, state_d;
	logic [IDX_W-1:0] rank_q, rank_d;
	logic [CNT_W-1:0] rank_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rank_q <= '0;
		end else begin
			state_q <= state_d;
			rank_q <= rank_d;
		end
	end

	assign rank_next = CNT_W'(rank_q) + CNT_W'(1);

	always_comb begin
		state_d = state_q;
		rank_d = '0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (opcode == OP_INSERT) begin
						cmd.insert = 1'b1;
					end else if (opcode == OP_CLEAR) begin
						cmd.clear = 1'b1;
					end else if (opcode == OP_READ) begin
						if (fill == '0) begin
							cmd.emit_empty = 1'b1;
						end else begin
							state_d = ST_READ;
						end
					end
				end
			end
			ST_READ: begin
				cmd.emit = 1'b1;
				cmd.last = (rank_next == fill);
				if (cmd.last) begin
					state_d = ST_IDLE;
				end else begin
					rank_d = rank_next[IDX_W-1:0];
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q == ST_READ);
	assign rank = rank_q;

endmodule

`default_nettype wire

FILE: rtl/core/tkil_dpath.sv
// Datapath of the top-k insertion list: the sorted shift-insert chain, the fill
// count, the limit register and the registered result word. Uses tkil_pkg.
`default_nettype none

module tkil_dpath #(
	parameter int MAX_ENTRIES = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tkil_pkg::cmd_t cmd,
	input  wire logic [IDX_W-1:0] rank,
	input  wire logic [tkil_pkg::SCORE_BITS-1:0] cand_score,
	input  wire logic [tkil_pkg::ID_BITS-1:0] cand_id,
	input  wire logic cfg_we,
	input  wire logic [tkil_pkg::LIMIT_BITS-1:0] cfg_wdata,
	output logic [CNT_W-1:0] fill,
	output logic strobe,
	output tkil_pkg::rsp_t rsp
);
	import tkil_pkg::*;

	localparam int LW = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;

	logic [SCORE_BITS-1:0] score_q [MAX_ENTRIES];
	logic [ID_BITS-1:0] id_q [MAX_ENTRIES];
	logic [CNT_W-1:0] fill_q, fill_d, fill_inc;
	logic [LIMIT_BITS-1:0] limit_q;
	logic [CNT_W-1:0] eff_lim;
	logic [LW-1:0] lim_ext;
	logic [MAX_ENTRIES-1:0] gt, prev_gt, ins_here, append_here;
	logic any_gt, do_append;
	logic strobe_q;
	rsp_t rsp_q;
	logic [IDX_W+RANK_BITS-1:0] rank_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// A limit of zero acts as one, and one above the built depth as the depth.
	always_comb begin
		lim_ext = LW'(limit_q);
		if (lim_ext == '0) begin
			eff_lim = CNT_W'(1);
		end else if (lim_ext > LW'(MAX_ENTRIES)) begin
			eff_lim = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_lim = lim_ext[CNT_W-1:0];
		end
	end

	// The stored scores ascend, so the set of valid entries larger than the
	// candidate is contiguous; its first member is where the candidate goes.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			gt[i] = (CNT_W'(i) < fill_q) && (cand_score < score_q[i]);
		end
		prev_gt[0] = 1'b0;
		for (int i = 1; i < MAX_ENTRIES; i++) begin
			prev_gt[i] = gt[i-1];
		end
		any_gt = |gt;
		do_append = !any_gt && (fill_q < eff_lim);
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			ins_here[i] = gt[i] && !prev_gt[i];
			append_here[i] = do_append && (CNT_W'(i) == fill_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (ins_here[0] || append_here[0]) begin
				score_q[0] <= cand_score;
				id_q[0] <= cand_id;
			end
			for (int i = 1; i < MAX_ENTRIES; i++) begin
				if (ins_here[i] || append_here[i]) begin
					score_q[i] <= cand_score;
					id_q[i] <= cand_id;
				end else if (prev_gt[i]) begin
					score_q[i] <= score_q[i-1];
					id_q[i] <= id_q[i-1];
				end
			end
		end
	end

	always_comb begin
		fill_inc = (fill_q < CNT_W'(MAX_ENTRIES)) ? fill_q + CNT_W'(1) : fill_q;
		fill_d = fill_q;
		if (cmd.clear) begin
			fill_d = '0;
		end else if (cmd.insert) begin
			if (any_gt) begin
				fill_d = (fill_inc > eff_lim) ? fill_inc - CNT_W'(1) : fill_inc;
			end else if (do_append) begin
				fill_d = fill_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	assign rank_ext = {{RANK_BITS{1'b0}}, rank};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit || cmd.emit_empty;
		end
	end

	// An empty list reads out as a single word marked invalid.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.entry_valid <= 1'b1;
			rsp_q.entry_score <= score_q[rank];
			rsp_q.entry_id <= id_q[rank];
			rsp_q.entry_rank <= rank_ext[RANK_BITS-1:0];
			rsp_q.last_entry <= cmd.last;
		end else if (cmd.emit_empty) begin
			rsp_q.entry_valid <= 1'b0;
			rsp_q.entry_score <= '0;
			rsp_q.entry_id <= '0;
			rsp_q.entry_rank <= '0;
			rsp_q.last_entry <= 1'b1;
		end
	end

	assign fill = fill_q;
	assign strobe = strobe_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/core/top_k_insertion_list_top.sv
// Top level of the top-k insertion list: joins the controller and datapath.
// Depends on tkil_pkg, tkil_ctrl and tkil_dpath.
//
//   channel   ports                    handshake
//   command   start, busy, req         taken when start is high and busy low
//   result    strobe, rsp              one word per strobe cycle, no back-pressure
//   config    cfg_we, cfg_wdata        result_limit written when cfg_we is high
//
// An insert or a clear leaves busy low, so commands of that kind may follow every
// cycle. A read holds busy high while the rank counter walks the stored entries;
// each word is registered and appears on rsp in the next cycle. An empty read
// gives one invalid word and leaves busy low. Reset empties the list and sets the
// limit to 16; the receiver cannot stall the results.
`default_nettype none

module top_k_insertion_list_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire tkil_pkg::req_t req,
	output logic strobe,
	output tkil_pkg::rsp_t rsp,
	input  wire logic cfg_we,
	input  wire logic [tkil_pkg::LIMIT_BITS-1:0] cfg_wdata
);
	import tkil_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	cmd_t cmd;
	logic [IDX_W-1:0] rank;
	logic [CNT_W-1:0] fill;

	tkil_ctrl #(
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(req.opcode),
		.fill(fill),
		.busy(busy),
		.cmd(cmd),
		.rank(rank)
	);

	tkil_dpath #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rank(rank),
		.cand_score(req.cand_score),
		.cand_id(req.cand_id),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fill(fill),
		.strobe(strobe),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

FILE: verif/top_k_insertion_list_checker.sv
`timescale 1ns / 1ps
// Checker for the top-k insertion list. It watches the command, config and result ports,
// keeps its own ranked copy of the list and compares every result word in order.
// Depends on tkil_pkg only.

module top_k_insertion_list_checker #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  tkil_pkg::req_t req,
	input  logic strobe,
	input  tkil_pkg::rsp_t rsp,
	input  logic cfg_we,
	input  logic [tkil_pkg::LIMIT_BITS-1:0] cfg_wdata,
	output int fail_count,
	output int pending_count,
	output int checked_count
);

	import tkil_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [SCORE_BITS-1:0] rank_score [DEPTH];
	logic [ID_BITS-1:0] rank_id [DEPTH];
	int fill;
	logic [LIMIT_BITS-1:0] limit_reg;
	rsp_t expected_words[$];

	// A limit of zero behaves as one, and anything past the built depth as the depth.
	function automatic int active_limit();
		int lim;
		lim = int'(limit_reg);
		if (lim < 1)
			lim = 1;
		if (lim > DEPTH)
			lim = DEPTH;
		return lim;
	endfunction

	task automatic insert_candidate(input logic [SCORE_BITS-1:0] score,
			input logic [ID_BITS-1:0] id);
		int lim;
		int pos;
		int top_idx;
		lim = active_limit();
		pos = 0;
		if (fill == 0) begin
			rank_score[0] = score;
			rank_id[0] = id;
			fill = 1;
			return;
		end
		while (pos < fill && !(score < rank_score[pos]))
			pos++;
		if (pos < fill) begin
			// Shift the tail down; whatever falls past the built depth is lost.
			top_idx = (fill >= DEPTH) ? DEPTH - 1 : fill;
			for (int i = top_idx; i > pos; i--) begin
				rank_score[i] = rank_score[i-1];
				rank_id[i] = rank_id[i-1];
			end
			rank_score[pos] = score;
			rank_id[pos] = id;
			if (fill < DEPTH)
				fill++;
			if (fill > lim)
				fill--;
		end else if (fill < lim) begin
			rank_score[fill] = score;
			rank_id[fill] = id;
			fill++;
		end
	endtask

	task automatic queue_readout();
		rsp_t w;
		if (fill == 0) begin
			w = '0;
			w.last_entry = 1'b1;
			expected_words = {expected_words, w};
		end else begin
			for (int k = 0; k < fill; k++) begin
				w.entry_valid = 1'b1;
				w.entry_score = rank_score[k];
				w.entry_id = rank_id[k];
				w.entry_rank = RANK_BITS'(k);
				w.last_entry = (k + 1 == fill);
				expected_words = {expected_words, w};
			end
		end
	endtask

	task automatic compare_word(input rsp_t got);
		rsp_t want;
		logic bad;
		if (expected_words.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: result word with nothing expected: valid=%0b score=%h id=%h rank=%0d last=%0b",
					$time, got.entry_valid, got.entry_score, got.entry_id,
					got.entry_rank, got.last_entry);
			return;
		end
		want = expected_words.pop_front();
		checked_count++;
		bad = (got.entry_valid !== want.entry_valid) || (got.entry_score !== want.entry_score)
			|| (got.entry_id !== want.entry_id) || (got.entry_rank !== want.entry_rank)
			|| (got.last_entry !== want.last_entry);
		if (bad) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT) begin
				$display("%0t: word mismatch, expected valid=%0b score=%h id=%h rank=%0d last=%0b",
					$time, want.entry_valid, want.entry_score, want.entry_id,
					want.entry_rank, want.last_entry);
				$display("%0t:                actual   valid=%0b score=%h id=%h rank=%0d last=%0b",
					$time, got.entry_valid, got.entry_score, got.entry_id,
					got.entry_rank, got.last_entry);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			limit_reg = LIMIT_RESET;
			expected_words.delete();
			fail_count = 0;
			checked_count = 0;
			for (int i = 0; i < DEPTH; i++) begin
				rank_score[i] = '0;
				rank_id[i] = '0;
			end
		end else begin
			// Words in flight belong to earlier reads, so they are checked first.
			if (strobe)
				compare_word(rsp);
			if (cfg_we)
				limit_reg = cfg_wdata;
			if (start && !busy) begin
				case (req.opcode)
					OP_INSERT: insert_candidate(req.cand_score, req.cand_id);
					OP_READ: queue_readout();
					OP_CLEAR: fill = 0;
					default: ;
				endcase
			end
		end
		pending_count = expected_words.size();
	end

endmodule

FILE: verif/top_k_insertion_list_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the top-k insertion list: clock, reset, command and config stimulus.
// Depends on tkil_pkg, top_k_insertion_list_top and top_k_insertion_list_checker.

module top_k_insertion_list_top_test;

	import tkil_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 320;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 20;
	localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic strobe;
	rsp_t rsp;
	logic cfg_we;
	logic [LIMIT_BITS-1:0] cfg_wdata;

	int fail_count;
	int pending_count;
	int checked_count;
	int cycle_count = 0;

	int items_sent;
	int inserts_sent;
	int reads_sent;
	int settings_used;
	int random_items;
	int score_mode;
	int phase_len;
	int pick;
	int gap;
	logic no_idle;
	logic [OPCODE_BITS-1:0] op;

	top_k_insertion_list_top #(
		.MAX_ENTRIES(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.strobe(strobe),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	top_k_insertion_list_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.strobe(strobe),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.checked_count(checked_count)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words still expected.",
				cycle_count, pending_count);
			$display("top_k_insertion_list_top_test: FAIL");
			$finish;
		end
	end

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Narrow ranges give plenty of equal scores, so tie ordering gets exercised.
	function automatic logic [SCORE_BITS-1:0] pick_score(input int mode);
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		case (mode)
			1: return SCORE_BITS'($urandom_range(0, 15));
			2: return {SCORE_BITS{1'b1}} - SCORE_BITS'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [LIMIT_BITS-1:0] pick_limit();
		case ($urandom_range(0, 9))
			0: return 5'd1;
			1: return LIMIT_RESET;
			2: return 5'd0;
			3: return 5'd31;
			4: return 5'd2;
			5: return 5'd17;
			6: return 5'd8;
			default: return LIMIT_BITS'($urandom_range(0, 31));
		endcase
	endfunction

	task automatic send_command(input logic [OPCODE_BITS-1:0] opcode,
			input logic [SCORE_BITS-1:0] score, input logic [ID_BITS-1:0] id,
			input int idle_cycles);
		repeat (idle_cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req.opcode <= opcode;
		req.cand_score <= score;
		req.cand_id <= id;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
		if (opcode == OP_INSERT)
			inserts_sent++;
		if (opcode == OP_READ)
			reads_sent++;
	endtask

	// Holds the sender off until every expected word has come and the block is quiet.
	task automatic settle_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_count != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
		settle_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		items_sent = 0;
		inserts_sent = 0;
		reads_sent = 0;
		settings_used = 0;
		random_items = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty read, extremes, ties, ignored opcode and clear.
		send_command(OP_READ, 32'h0, 32'h0, 0);
		send_command(OP_INSERT, 32'h0, 32'h0, 0);
		send_command(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_command(OP_INSERT, 32'd5, 32'hAAAA_AAAA, pick_gap());
		send_command(OP_INSERT, 32'd5, 32'h5555_5555, 0);
		send_command(OP_INSERT, 32'h0, 32'd1, 0);
		send_command(OP_UNUSED, 32'hDEAD_BEEF, 32'h1234_5678, 0);
		send_command(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_command(OP_CLEAR, 32'h0, 32'h0, 2);
		send_command(OP_READ, 32'h0, 32'h0, 0);

		// A small limit: a full list ignores an append but takes a better score.
		write_limit(5'd2);
		send_command(OP_INSERT, 32'd10, 32'd100, 0);
		send_command(OP_INSERT, 32'd20, 32'd200, 0);
		send_command(OP_INSERT, 32'd30, 32'd300, 0);
		send_command(OP_INSERT, 32'd5, 32'd50, 1);
		send_command(OP_READ, 32'h0, 32'h0, 0);

		// Lowering the limit below the fill keeps the entries already stored.
		write_limit(LIMIT_RESET);
		send_command(OP_INSERT, 32'd7, 32'd70, 0);
		send_command(OP_INSERT, 32'd8, 32'd80, 0);
		send_command(OP_INSERT, 32'd9, 32'd90, 0);
		write_limit(5'd0);
		send_command(OP_INSERT, 32'd6, 32'd60, 0);
		send_command(OP_INSERT, 32'd100, 32'd1000, 0);
		send_command(OP_READ, 32'h0, 32'h0, 0);
		write_limit(5'd31);

		while (random_items < RANDOM_ITEMS) begin
			write_limit(pick_limit());
			score_mode = $urandom_range(0, 2);
			no_idle = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(10, 50);
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				gap = no_idle ? 0 : pick_gap();
				if (pick < 70) begin
					op = OP_INSERT;
				end else if (pick < 88) begin
					op = OP_READ;
				end else if (pick < 91) begin
					op = OP_CLEAR;
				end else if (pick < 95) begin
					op = OP_UNUSED;
				end else begin
					settle_idle();
					op = OP_READ;
				end
				send_command(op, pick_score(score_mode), $urandom, gap);
				if (op != OP_UNUSED)
					random_items++;
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES)
			@(negedge clk);

		$display("Sent %0d commands (%0d inserts, %0d reads) under %0d limit settings.",
			items_sent, inserts_sent, reads_sent, settings_used);
		$display("Compared %0d result words against the predicted ranking.", checked_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("top_k_insertion_list_top_test: PASS");
		end else begin
			$display("%0d failures, %0d words never arrived.", fail_count, pending_count);
			$display("top_k_insertion_list_top_test: FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tkil_pkg.sv
rtl/core/tkil_ctrl.sv
rtl/core/tkil_dpath.sv
rtl/core/top_k_insertion_list_top.sv
verif/top_k_insertion_list_checker.sv
verif/top_k_insertion_list_top_test.sv
